// File: sv/heartbeat_membership_table_top_macros.svh
// Assertion helpers for the membership table.
// Both sample on i_clk and switch off while i_rst_n is low.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_TOP_MACROS_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HMT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Consequent checked in the cycle after the antecedent.
`define HMT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// File: sv/hmt_pkg.sv
package hmt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W   = 32;
    localparam int PORT_W = 16;
    localparam int HB_W   = 32;
    localparam int TIME_W = 32;
    localparam int TMO_W  = 16;

    // introducer address
    localparam logic [ID_W-1:0]   INTRO_ID   = ID_W'(1);
    localparam logic [PORT_W-1:0] INTRO_PORT = '0;

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_JOIN_REQ = 3'd1,
        REQ_JOIN_REP = 3'd2,
        REQ_GOSSIP   = 3'd3,
        REQ_TICK     = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        CFG_SELF_ID   = 2'd0,
        CFG_SELF_PORT = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ONE,
        S_SWEEP,
        S_LOOK
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   self_id;
        logic [PORT_W-1:0] self_port;
        logic [TMO_W-1:0]  fail_timeout;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ID_W-1:0]   node_id;
        logic [PORT_W-1:0] node_port;
        logic [HB_W-1:0]   heartbeat;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   heartbeat;
        logic [TIME_W-1:0] stamp;
    } t_slot;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   entry_node_id;
        logic [PORT_W-1:0] entry_node_port;
        logic [HB_W-1:0]   entry_heartbeat;
        logic              changed;
        logic              inserted;
        logic              table_full;
        logic              send_reply;
        logic              send_join;
        logic              in_group;
        logic              last;
    } t_res;

endpackage

// File: sv/hmt_slot_ram.sv
module hmt_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data held while i_rd_en is low
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/hmt_ctrl.sv
module hmt_ctrl
    import hmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_item_valid,
    output logic  o_item_ready,
    input  t_item i_item,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    output t_res  o_res
);

    t_state r_state, n_state;

    // item held for the whole walk
    t_req              r_req;
    logic [ID_W-1:0]   r_key_id, n_key_id;
    logic [PORT_W-1:0] r_key_port, n_key_port;
    logic [HB_W-1:0]   r_key_hb, n_key_hb;
    logic [TIME_W-1:0] r_now;

    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [HB_W-1:0]        r_own_hb, n_own_hb;
    logic                   r_group, n_group;

    // walk pipeline: read address, then compare stage
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_cv, n_cv;
    logic [IDX_W-1:0] r_cidx, n_cidx;
    logic             r_free_found, n_free_found;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;

    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    t_slot             ram_wr_data;
    logic              ram_rd_en;
    logic [$bits(t_slot)-1:0] ram_rd_raw;
    t_slot             cmp;

    logic accept, hit, expired, walk_end, hb_gt, intro, stall;

    hmt_slot_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(t_slot))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (ram_rd_raw)
    );

    assign cmp      = t_slot'(ram_rd_raw);
    assign accept   = i_item_valid && o_item_ready;
    assign hit      = r_cv && r_valid[r_cidx] &&
                      (cmp.id == r_key_id) && (cmp.port == r_key_port);
    assign expired  = r_cv && r_valid[r_cidx] &&
                      ((r_now - cmp.stamp) > TIME_W'(i_cfg.fail_timeout));
    assign walk_end = !r_cv && (r_addr == CNT_W'(TABLE_DEPTH));
    assign hb_gt    = r_key_hb > cmp.heartbeat;
    assign intro    = (i_cfg.self_id == INTRO_ID) && (i_cfg.self_port == INTRO_PORT);
    assign stall    = o_res_valid && !i_res_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_req'(i_item.req_type) inside {REQ_JOIN_REQ, REQ_JOIN_REP,
                                                        REQ_GOSSIP}) begin
                        n_state = S_LOOK;
                    end else if ((t_req'(i_item.req_type) == REQ_TICK) && r_group) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_ONE;
                    end
                end
            end
            S_ONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (walk_end) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if ((hit || walk_end) && i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: result word and memory port
    always_comb begin
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.in_group = r_group;
        o_res.last   = 1'b1;
        ram_rd_en    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_cidx;
        ram_wr_data  = '{id: r_key_id, port: r_key_port, heartbeat: r_key_hb, stamp: r_now};
        case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
            end
            S_ONE: begin
                o_res_valid = 1'b1;
                if (r_req == REQ_START) begin
                    o_res.entry_node_id   = i_cfg.self_id;
                    o_res.entry_node_port = i_cfg.self_port;
                    o_res.changed         = 1'b1;
                    o_res.inserted        = 1'b1;
                    o_res.send_join       = !intro;
                    o_res.in_group        = intro;
                    ram_wr_en   = i_res_ready;
                    ram_wr_addr = '0;
                    ram_wr_data = '{id: i_cfg.self_id, port: i_cfg.self_port,
                                    heartbeat: '0, stamp: r_now};
                end
            end
            S_SWEEP: begin
                o_res_valid           = expired;
                o_res.kind            = 1'b1;
                o_res.entry_node_id   = cmp.id;
                o_res.entry_node_port = cmp.port;
                o_res.entry_heartbeat = cmp.heartbeat;
                o_res.changed         = 1'b1;
                o_res.last            = 1'b0;
                ram_rd_en = !stall && (r_addr < CNT_W'(TABLE_DEPTH));
            end
            S_LOOK: begin
                o_res_valid           = hit || walk_end;
                o_res.entry_node_id   = r_key_id;
                o_res.entry_node_port = r_key_port;
                o_res.send_reply      = (r_req == REQ_JOIN_REQ);
                if (hit) begin
                    o_res.entry_heartbeat = hb_gt ? r_key_hb : cmp.heartbeat;
                    o_res.changed         = hb_gt;
                    ram_wr_en             = hb_gt && i_res_ready;
                end else begin
                    o_res.entry_heartbeat = r_key_hb;
                    o_res.changed         = r_free_found;
                    o_res.inserted        = r_free_found;
                    o_res.table_full      = !r_free_found;
                    ram_wr_en             = walk_end && r_free_found && i_res_ready;
                    ram_wr_addr           = r_free_idx;
                end
                ram_rd_en = !hit && (r_addr < CNT_W'(TABLE_DEPTH));
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_key_id     = r_key_id;
        n_key_port   = r_key_port;
        n_key_hb     = r_key_hb;
        n_valid      = r_valid;
        n_own_hb     = r_own_hb;
        n_group      = r_group;
        n_addr       = r_addr;
        n_cv         = r_cv;
        n_cidx       = r_cidx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key_id     = i_item.node_id;
                    n_key_port   = i_item.node_port;
                    n_key_hb     = i_item.heartbeat;
                    n_addr       = '0;
                    n_cv         = 1'b0;
                    n_free_found = 1'b0;
                    if (t_req'(i_item.req_type) == REQ_JOIN_REP) begin
                        n_group = 1'b1;
                    end
                end
            end
            S_ONE: begin
                if (i_res_ready && (r_req == REQ_START)) begin
                    n_valid    = '0;
                    n_valid[0] = 1'b1;
                    n_own_hb   = '0;
                    n_group    = intro;
                end
            end
            S_SWEEP: begin
                if (!stall) begin
                    n_cv   = ram_rd_en;
                    n_cidx = r_addr[IDX_W-1:0];
                    if (ram_rd_en) begin
                        n_addr = r_addr + CNT_W'(1);
                    end
                    if (expired) begin
                        n_valid[r_cidx] = 1'b0;
                    end
                end
                if (walk_end) begin
                    // own entry refresh follows as an ordinary lookup
                    n_own_hb     = r_own_hb + HB_W'(1);
                    n_key_hb     = r_own_hb + HB_W'(1);
                    n_key_id     = i_cfg.self_id;
                    n_key_port   = i_cfg.self_port;
                    n_addr       = '0;
                    n_cv         = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            S_LOOK: begin
                if (!hit) begin
                    n_cv   = ram_rd_en;
                    n_cidx = r_addr[IDX_W-1:0];
                    if (ram_rd_en) begin
                        n_addr = r_addr + CNT_W'(1);
                    end
                end
                if (r_cv && !r_valid[r_cidx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cidx;
                end
                if (walk_end && r_free_found && i_res_ready) begin
                    n_valid[r_free_idx] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_own_hb     <= '0;
            r_group      <= 1'b0;
            r_cv         <= 1'b0;
            r_addr       <= '0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_own_hb     <= n_own_hb;
            r_group      <= n_group;
            r_cv         <= n_cv;
            r_addr       <= n_addr;
            r_free_found <= n_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_item.req_type);
            r_now <= i_item.now;
        end
        r_key_id   <= n_key_id;
        r_key_port <= n_key_port;
        r_key_hb   <= n_key_hb;
        r_cidx     <= n_cidx;
        r_free_idx <= n_free_idx;
    end

endmodule

// File: sv/heartbeat_membership_table_top.sv
// Membership table of a gossip heartbeat failure detector.
// Input channel (i_valid/o_ready): one word per request; start, join request,
// join reply, gossip heartbeat or tick, with sender address, heartbeat and time.
// Output channel (o_valid/i_ready): result words; a tick gives one removal
// notice per timed-out slot in slot order, then a closing word with o_last set.
// Every other request, and a tick outside the group, gives a single word with o_last set.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): own id, own port and
// failure timeout; the user writes them only while the block is idle, which the block does not enforce.
// Slot contents live in a single-port-write, registered-read RAM walked one
// slot per cycle unless a stalled output holds the sweep; valid bits sit in flops.
// One request is in flight at a time; o_ready drops after acceptance.
// A stalled receiver holds the output register, and the walk pauses on the
// next word it has to emit; nothing is lost.
// Reset clears the valid bits, the membership flag, own heartbeat and the
// config registers at once (timeout to 5); no clearing pass is run.
`include "heartbeat_membership_table_top_macros.svh"

module heartbeat_membership_table_top
    import hmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request words
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req_type,
    input  logic [ID_W-1:0]   i_node_id,
    input  logic [PORT_W-1:0] i_node_port,
    input  logic [HB_W-1:0]   i_heartbeat,
    input  logic [TIME_W-1:0] i_now,
    // result words
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [ID_W-1:0]   o_entry_node_id,
    output logic [PORT_W-1:0] o_entry_node_port,
    output logic [HB_W-1:0]   o_entry_heartbeat,
    output logic              o_changed,
    output logic              o_inserted,
    output logic              o_table_full,
    output logic              o_send_reply,
    output logic              o_send_join,
    output logic              o_in_group,
    output logic              o_last,
    // config writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    t_cfg  r_cfg;
    t_item item;
    t_res  res;
    logic  res_valid;
    logic  res_ready;

    // output register: parts the table walk from the receiver
    logic  r_out_valid;
    t_res  r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.self_id      <= '0;
            r_cfg.self_port    <= '0;
            r_cfg.fail_timeout <= TMO_W'(5);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SELF_ID:   r_cfg.self_id      <= i_cfg_data;
                CFG_SELF_PORT: r_cfg.self_port    <= i_cfg_data[PORT_W-1:0];
                CFG_TIMEOUT:   r_cfg.fail_timeout <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    assign item = '{req_type: i_req_type, node_id: i_node_id, node_port: i_node_port,
                    heartbeat: i_heartbeat, now: i_now};

    hmt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (i_valid),
        .o_item_ready (o_ready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_kind            = r_out.kind;
    assign o_entry_node_id   = r_out.entry_node_id;
    assign o_entry_node_port = r_out.entry_node_port;
    assign o_entry_heartbeat = r_out.entry_heartbeat;
    assign o_changed         = r_out.changed;
    assign o_inserted        = r_out.inserted;
    assign o_table_full      = r_out.table_full;
    assign o_send_reply      = r_out.send_reply;
    assign o_send_join       = r_out.send_join;
    assign o_in_group        = r_out.in_group;
    assign o_last            = r_out.last;

    // nothing is emitted while waiting for a request
    `HMT_ASSERT_SAME(a_idle_quiet, o_ready, !res_valid)
    // an accepted request keeps the block busy in the following cycle
    `HMT_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // only removal notices leave without the closing flag
    `HMT_ASSERT_SAME(a_notice_not_last, res_valid && !res.last, res.kind && res.in_group)

endmodule
